>>> hdl/key_map_rle_text_loader_top_assert.svh
// assertion macros for the key map loader top level
// expects clk and rst to be visible where a macro is used
`ifndef KEY_MAP_RLE_TEXT_LOADER_TOP_ASSERT_SVH
`define KEY_MAP_RLE_TEXT_LOADER_TOP_ASSERT_SVH

// same-cycle implication
`define KMRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KMRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/kmrl_pkg.sv
// shared types and constants of the key map loader
// no dependencies
`default_nettype none

package kmrl_pkg;

  localparam int TABLE_KEYS       = 2048;
  // default mapping splits the index by shift and mask, so this stays a power of two
  localparam int KEYS_PER_CHANNEL = 128;
  localparam int ADDR_W           = $clog2(TABLE_KEYS);
  localparam int KEY_SHIFT        = $clog2(KEYS_PER_CHANNEL);
  // sum of chunk start, position and run offset
  localparam int RUN_ADDR_W       = 18;

  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic MODE_TEXT   = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  typedef struct packed {
    logic       flag;
    logic [6:0] key;
    logic [6:0] chan;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } wr_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [6:0] key;
    logic [6:0] chan;
    logic       ov;
    logic       dropped;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic running;
  } stat_t;

endpackage

`default_nettype wire

>>> hdl/kmrl_ifs.sv
// request and result channel interfaces of the key map loader
// no dependencies
`default_nettype none

interface kmrl_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  char_code;
  logic [10:0] lookup_index;

  modport source (output valid, mode, char_code, lookup_index, input ready);
  modport sink (input valid, mode, char_code, lookup_index, output ready);
endinterface

interface kmrl_rsp_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [6:0] mapped_key;
  logic [6:0] mapped_channel;
  logic       is_overridden;
  logic       writes_dropped;

  modport source (output valid, result_kind, mapped_key, mapped_channel, is_overridden,
                  writes_dropped, input ready);
  modport sink (input valid, result_kind, mapped_key, mapped_channel, is_overridden,
                writes_dropped, output ready);
endinterface

`default_nettype wire

>>> hdl/kmrl_table.sv
// override table memory: one write port, one registered read port
// depends on kmrl_pkg
`default_nettype none

module kmrl_table
  import kmrl_pkg::*;
(
  input  wire logic              clk,
  input  wire wr_t               wr,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output entry_t                 rd_data
);

  entry_t mem [TABLE_KEYS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/kmrl_seq.sv
// parser sequencer: text parsing, run expansion, table clearing and lookups
// depends on kmrl_pkg and kmrl_ifs
`default_nettype none

module kmrl_seq
  import kmrl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  kmrl_req_if.sink               request,
  input  wire logic              out_free,
  input  wire entry_t            rd_data,
  output wr_t                    wr,
  output logic                   rd_en,
  output logic [ADDR_W-1:0]      rd_addr,
  output res_t                   res,
  output stat_t                  stat
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHAR  = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_LOOK  = 3'd5;

  logic [2:0]            state, state_next;
  logic [ADDR_W-1:0]     clr_addr, clr_addr_next;
  logic                  pend, pend_next;
  logic                  dirty, dirty_next;
  logic                  starting, starting_next;
  logic                  drop, drop_next;
  logic [15:0]           acc, acc_next;
  logic [15:0]           start, start_next;
  logic [15:0]           pos, pos_next;
  logic [15:0]           run_len, run_len_next;
  logic [6:0]            last_key, last_key_next;
  logic [6:0]            last_chan, last_chan_next;

  logic [7:0]            chr;
  logic [10:0]           idx;
  logic [RUN_ADDR_W-1:0] run_addr, run_addr_next;
  logic [15:0]           run_cnt, run_cnt_next;

  logic [RUN_ADDR_W-1:0] base;
  logic                  put_req;
  logic [RUN_ADDR_W-1:0] put_addr;
  logic [6:0]            put_key, put_chan;
  logic [15:0]           acc_x10;
  logic [15:0]           adv;
  logic [16:0]           pos_sum;
  logic [6:0]            step_key, step_chan;
  logic [6:0]            dflt_key, dflt_chan;
  logic                  idx_ok;
  logic                  accept;

  assign accept  = request.valid && request.ready;
  assign base    = RUN_ADDR_W'(start) + RUN_ADDR_W'(pos);
  assign acc_x10 = {acc[12:0], 3'b000} + {acc[14:0], 1'b0};
  assign adv     = (run_len != 16'd0) ? run_len : 16'd1;
  assign pos_sum = 17'(pos) + 17'(adv);
  assign rd_addr = ADDR_W'(request.lookup_index);

  // one default step: key wraps into the next channel
  always_comb begin
    if (({1'b0, last_key} + 8'd1) >= 8'(KEYS_PER_CHANNEL)) begin
      step_key  = 7'd0;
      step_chan = last_chan + 7'd1;
    end else begin
      step_key  = last_key + 7'd1;
      step_chan = last_chan;
    end
  end

  assign dflt_key  = 7'(idx & 11'(KEYS_PER_CHANNEL - 1));
  assign dflt_chan = 7'((idx >> KEY_SHIFT) + 11'd1);
  assign idx_ok    = 32'(idx) < TABLE_KEYS;

  assign stat.clearing = (state == S_CLEAR);
  assign stat.running  = (state == S_RUN);

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    pend_next      = pend;
    dirty_next     = dirty;
    starting_next  = starting;
    drop_next      = drop;
    acc_next       = acc;
    start_next     = start;
    pos_next       = pos;
    run_len_next   = run_len;
    last_key_next  = last_key;
    last_chan_next = last_chan;
    run_addr_next  = run_addr;
    run_cnt_next   = run_cnt;
    put_req        = 1'b0;
    put_addr       = base;
    put_key        = last_key;
    put_chan       = last_chan;
    wr             = '0;
    rd_en          = 1'b0;
    res            = '0;
    request.ready  = 1'b0;

    case (state)
      S_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_addr;
        if (clr_addr == ADDR_W'(TABLE_KEYS - 1)) begin
          clr_addr_next = '0;
          dirty_next    = 1'b0;
          pend_next     = 1'b0;
          state_next    = pend ? S_CHAR : S_IDLE;
        end else begin
          clr_addr_next = clr_addr + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        request.ready = 1'b1;
        if (request.valid) begin
          if (request.mode == MODE_LOOKUP) begin
            rd_en      = 1'b1;
            state_next = S_LOOK;
          end else begin
            state_next = S_CHAR;
          end
        end
      end
      S_CHAR: begin
        if (starting) begin
          // first character of a string: wipe overrides and parser state
          starting_next  = 1'b0;
          drop_next      = 1'b0;
          acc_next       = '0;
          start_next     = '0;
          pos_next       = '0;
          run_len_next   = '0;
          last_key_next  = '0;
          last_chan_next = '0;
          if (dirty) begin
            pend_next  = 1'b1;
            state_next = S_CLEAR;
          end
        end else if (chr >= CH_ZERO && chr <= CH_NINE) begin
          acc_next   = acc_x10 + 16'(chr - CH_ZERO);
          state_next = S_IDLE;
        end else if (chr == CH_COLON) begin
          start_next = acc;
          acc_next   = '0;
          state_next = S_IDLE;
        end else if (chr == CH_SLASH) begin
          last_key_next = acc[6:0];
          acc_next      = '0;
          state_next    = S_IDLE;
        end else if (chr == CH_PLUS) begin
          run_len_next = acc;
          acc_next     = '0;
          state_next   = S_IDLE;
        end else if (chr == CH_COMMA || chr == CH_SPACE || chr == CH_END) begin
          acc_next = '0;
          if (run_len != 16'd0) begin
            run_addr_next = base;
            run_cnt_next  = run_len;
            state_next    = S_RUN;
          end else begin
            last_chan_next = acc[6:0];
            put_req        = (acc[6:0] != 7'd0);
            put_chan       = acc[6:0];
            state_next     = S_FIN;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RUN: begin
        last_key_next  = step_key;
        last_chan_next = step_chan;
        put_req        = 1'b1;
        put_addr       = run_addr;
        put_key        = step_key;
        put_chan       = step_chan;
        run_addr_next  = run_addr + RUN_ADDR_W'(1);
        run_cnt_next   = run_cnt - 16'd1;
        if (run_cnt == 16'd1) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        run_len_next = '0;
        if (chr == CH_COMMA) begin
          pos_next   = pos_sum[16] ? 16'hFFFF : pos_sum[15:0];
          state_next = S_IDLE;
        end else begin
          pos_next = '0;
          if (chr != CH_END) begin
            state_next = S_IDLE;
          end else if (out_free) begin
            res.valid     = 1'b1;
            res.kind      = KIND_DONE;
            res.dropped   = drop;
            starting_next = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      S_LOOK: begin
        if (out_free) begin
          res.valid = 1'b1;
          res.kind  = KIND_LOOKUP;
          if (idx_ok && rd_data.flag) begin
            res.key  = rd_data.key;
            res.chan = rd_data.chan;
            res.ov   = (rd_data.key != dflt_key) || (rd_data.chan != dflt_chan);
          end else begin
            res.key  = dflt_key;
            res.chan = dflt_chan;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // shared range check for every table write of the parser
    if (put_req) begin
      if (put_addr < RUN_ADDR_W'(TABLE_KEYS)) begin
        wr.en      = 1'b1;
        wr.addr    = ADDR_W'(put_addr);
        wr.data    = '{flag: 1'b1, key: put_key, chan: put_chan};
        dirty_next = 1'b1;
      end else begin
        drop_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      pend      <= 1'b0;
      dirty     <= 1'b0;
      starting  <= 1'b1;
      drop      <= 1'b0;
      acc       <= '0;
      start     <= '0;
      pos       <= '0;
      run_len   <= '0;
      last_key  <= '0;
      last_chan <= '0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      pend      <= pend_next;
      dirty     <= dirty_next;
      starting  <= starting_next;
      drop      <= drop_next;
      acc       <= acc_next;
      start     <= start_next;
      pos       <= pos_next;
      run_len   <= run_len_next;
      last_key  <= last_key_next;
      last_chan <= last_chan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chr <= request.char_code;
      idx <= request.lookup_index;
    end
    run_addr <= run_addr_next;
    run_cnt  <= run_cnt_next;
  end

endmodule

`default_nettype wire

>>> hdl/key_map_rle_text_loader_top.sv
// lookup: registered read, then output register; no new request until the result issues
// text: S_IDLE, S_CHAR per character; separators add S_FIN, after S_RUN if closing a run
// first character of a string: an extra S_CHAR pass, plus a clearing pass after writes
// reset: synchronous, active high; a clearing pass of the table follows with ready low
// one request in flight at a time; the output register holds one result
`default_nettype none

module key_map_rle_text_loader_top
  import kmrl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  kmrl_req_if.sink  request,
  kmrl_rsp_if.source result
);

  wr_t               wr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_data;
  res_t              res;
  stat_t             stat;
  logic              out_valid;
  res_t              out_data;
  logic              out_free;

  assign out_free = !out_valid || result.ready;

  kmrl_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .out_free (out_free),
    .rd_data  (rd_data),
    .wr       (wr),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .res      (res),
    .stat     (stat)
  );

  kmrl_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data <= res;
    end
  end

  assign result.valid          = out_valid;
  assign result.result_kind    = out_data.kind;
  assign result.mapped_key     = out_data.key;
  assign result.mapped_channel = out_data.chan;
  assign result.is_overridden  = out_data.ov;
  assign result.writes_dropped = out_data.dropped;

`include "key_map_rle_text_loader_top_assert.svh"

  `KMRL_ASSERT_NOW(a_busy_not_ready, stat.clearing || stat.running, !request.ready,
                   "request taken during clearing or run expansion")
  `KMRL_ASSERT_NOW(a_write_not_ready, wr.en, !request.ready, "table write while ready")
  `KMRL_ASSERT_NEXT(a_lookup_busy,
                    request.valid && request.ready && (request.mode == MODE_LOOKUP),
                    !request.ready, "lookup did not block the next request")
  `KMRL_ASSERT_NEXT(a_result_lands, res.valid, result.valid, "result lost before output")

endmodule

`default_nettype wire

>>> verif/key_map_rle_text_loader_top_tb.sv
// self-checking testbench for the key map loader: parses remap text and checks lookup and end-of-string results
// depends on kmrl_pkg, kmrl_req_if and kmrl_rsp_if from the rtl, and on key_map_rle_text_loader_top as the dut
`timescale 1ns / 1ps

module key_map_rle_text_loader_top_tb
  import kmrl_pkg::*;
();

  typedef struct packed {
    logic        mode;
    logic [7:0]  ch;
    logic [10:0] idx;
  } req_item_t;

  typedef struct packed {
    logic       kind;
    logic [6:0] key;
    logic [6:0] chan;
    logic       ov;
    logic       dropped;
  } answer_t;

  logic clk;
  logic rst;

  kmrl_req_if req_ch ();
  kmrl_rsp_if rsp_ch ();

  key_map_rle_text_loader_top dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (rsp_ch)
  );

  always #1 clk = ~clk;

  req_item_t pending_reqs[$];
  answer_t   expected_answers[$];
  req_item_t next_req;
  answer_t   want;
  int        errors = 0;
  int        stim_count = 0;
  int        cycle_count = 0;
  int        send_gap = 0;
  int        take_stall = 0;
  wire       steady = (cycle_count % 4000) < 700;

  // mirror of the remap table and the text parser
  logic [6:0]  map_key [TABLE_KEYS];
  logic [6:0]  map_chan [TABLE_KEYS];
  bit          map_set [TABLE_KEYS];
  logic [15:0] acc = '0;
  logic [15:0] start_at = '0;
  logic [15:0] pos = '0;
  logic [15:0] run_n = '0;
  logic [6:0]  prev_key = '0;
  logic [6:0]  prev_chan = '0;
  bit          new_string = 1'b1;
  bit          drop_flag = 1'b0;

  function automatic void store_entry(int unsigned addr, logic [6:0] k, logic [6:0] c);
    if (addr < TABLE_KEYS) begin
      map_key[addr]  = k;
      map_chan[addr] = c;
      map_set[addr]  = 1'b1;
    end else begin
      drop_flag = 1'b1;
    end
  endfunction

  // writes the pending entry or run, returns how far a comma moves the position
  function automatic int unsigned close_entry();
    int unsigned base;
    int unsigned k;
    int unsigned c;
    int unsigned n;
    int unsigned i;
    base = start_at + pos;
    if (run_n != 0) begin
      k = prev_key;
      c = prev_chan;
      n = run_n;
      for (i = 0; i < n; i++) begin
        k++;
        if (k >= KEYS_PER_CHANNEL) begin
          k = 0;
          c = (c + 1) & 127;
        end
        store_entry(base + i, 7'(k), 7'(c));
      end
      prev_key  = 7'(k);
      prev_chan = 7'(c);
      run_n     = '0;
      return n;
    end
    prev_chan = acc[6:0];
    if (prev_chan != 0) store_entry(base, prev_key, prev_chan);
    return 1;
  endfunction

  function automatic void note_request(req_item_t it);
    answer_t     a;
    logic [6:0]  dk;
    logic [6:0]  dc;
    int unsigned sum;
    a = '0;
    if (it.mode == MODE_LOOKUP) begin
      dk     = 7'(it.idx % KEYS_PER_CHANNEL);
      dc     = 7'(it.idx / KEYS_PER_CHANNEL + 1);
      a.kind = KIND_LOOKUP;
      a.key  = dk;
      a.chan = dc;
      if (it.idx < TABLE_KEYS && map_set[it.idx]) begin
        a.key  = map_key[it.idx];
        a.chan = map_chan[it.idx];
        a.ov   = (a.key != dk) || (a.chan != dc);
      end
      expected_answers.push_back(a);
      return;
    end
    if (new_string) begin
      map_set    = '{default: 1'b0};
      acc        = '0;
      start_at   = '0;
      pos        = '0;
      run_n      = '0;
      prev_key   = '0;
      prev_chan  = '0;
      drop_flag  = 1'b0;
      new_string = 1'b0;
    end
    if (it.ch >= CH_ZERO && it.ch <= CH_NINE) begin
      sum = acc * 10 + (it.ch - CH_ZERO);
      acc = 16'(sum);
    end else if (it.ch == CH_COLON) begin
      start_at = acc;
      acc      = '0;
    end else if (it.ch == CH_SLASH) begin
      prev_key = acc[6:0];
      acc      = '0;
    end else if (it.ch == CH_PLUS) begin
      run_n = acc;
      acc   = '0;
    end else if (it.ch == CH_COMMA) begin
      sum = pos + close_entry();
      pos = (sum > 65535) ? 16'hFFFF : 16'(sum);
      acc = '0;
    end else if (it.ch == CH_SPACE || it.ch == CH_END) begin
      void'(close_entry());
      pos = '0;
      acc = '0;
      if (it.ch == CH_END) begin
        a.kind     = KIND_DONE;
        a.dropped  = drop_flag;
        new_string = 1'b1;
        expected_answers.push_back(a);
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (send_gap != 0) begin
        req_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_reqs.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else begin
        next_req = pending_reqs.pop_front();
        req_ch.mode <= next_req.mode;
        req_ch.char_code <= next_req.ch;
        req_ch.lookup_index <= next_req.idx;
        req_ch.valid <= 1'b1;
        send_gap <= steady ? 0 : pick_gap();
      end
    end
  end

  // monitor: results are checked before the request of the same edge is applied
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      take_stall <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_answers.size() == 0) begin
          $error("result arrived with no request waiting for it");
          errors++;
        end else begin
          want = expected_answers.pop_front();
          if (rsp_ch.result_kind !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, rsp_ch.result_kind);
            errors++;
          end
          if (rsp_ch.mapped_key !== want.key) begin
            $error("mapped_key: expected %0d, got %0d", want.key, rsp_ch.mapped_key);
            errors++;
          end
          if (rsp_ch.mapped_channel !== want.chan) begin
            $error("mapped_channel: expected %0d, got %0d", want.chan, rsp_ch.mapped_channel);
            errors++;
          end
          if (rsp_ch.is_overridden !== want.ov) begin
            $error("is_overridden: expected %0d, got %0d", want.ov, rsp_ch.is_overridden);
            errors++;
          end
          if (rsp_ch.writes_dropped !== want.dropped) begin
            $error("writes_dropped: expected %0d, got %0d", want.dropped,
                   rsp_ch.writes_dropped);
            errors++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        note_request('{req_ch.mode, req_ch.char_code, req_ch.lookup_index});
      end
      if (take_stall != 0) begin
        rsp_ch.ready <= 1'b0;
        take_stall <= take_stall - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!steady && $urandom_range(9) == 0) take_stall <= pick_gap();
      end
    end
  end

  task automatic push_char(logic [7:0] c);
    pending_reqs.push_back('{MODE_TEXT, c, 11'($urandom_range(2047))});
    if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_COLON || c == CH_SLASH || c == CH_PLUS ||
        c == CH_COMMA || c == CH_SPACE || c == CH_END) stim_count++;
  endtask

  task automatic push_lookup(int unsigned idx);
    pending_reqs.push_back('{MODE_LOOKUP, 8'($urandom_range(255)), 11'(idx)});
    stim_count++;
  endtask

  task automatic push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_num(int unsigned v);
    push_text($sformatf("%0d", v));
  endtask

  // half of the time near the current chunk so that overrides get hit
  task automatic push_lookup_near(int unsigned base);
    if ($urandom_range(1) == 0) push_lookup((base + $urandom_range(24)) & 2047);
    else push_lookup($urandom_range(2047));
  endtask

  // one remap string: well formed chunks with random content, some noise and breakage
  task automatic gen_string();
    int unsigned chunks;
    int unsigned entries;
    int unsigned start;
    int unsigned pick;
    int unsigned ci;
    int unsigned ei;
    chunks = $urandom_range(3, 1);
    start = 0;
    for (ci = 0; ci < chunks; ci++) begin
      if (ci != 0) push_char(CH_SPACE);
      if ($urandom_range(9) < 8) begin
        pick = $urandom_range(9);
        if (pick < 6) start = $urandom_range(300);
        else if (pick < 9) start = $urandom_range(2047);
        else start = $urandom_range(99999, 1900);
        push_num(start);
        push_char(CH_COLON);
      end
      entries = $urandom_range(5, 1);
      for (ei = 0; ei < entries; ei++) begin
        if (ei != 0) push_char(CH_COMMA);
        pick = $urandom_range(19);
        if (pick < 13) begin
          push_num($urandom_range(9) == 0 ? $urandom_range(999) : $urandom_range(127));
          push_char(CH_SLASH);
          push_num($urandom_range(9) == 0 ? $urandom_range(300) : $urandom_range(16));
        end else if (pick < 18) begin
          push_num($urandom_range(19) == 0 ? $urandom_range(400, 13) : $urandom_range(12));
          push_char(CH_PLUS);
        end else if (pick == 18) begin
          push_char(CH_SLASH);
          push_num($urandom_range(20));
        end else begin
          push_num($urandom_range(127));
        end
        if ($urandom_range(3) == 0) push_lookup_near(start);
        if ($urandom_range(29) == 0) push_char(8'($urandom_range(255)));
      end
    end
    // some strings run on into the next one without a terminator
    if ($urandom_range(19) < 17) push_char(CH_END);
    repeat ($urandom_range(5, 1)) push_lookup_near(start);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_ch.valid || expected_answers.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_TEXT;
    req_ch.char_code = '0;
    req_ch.lookup_index = '0;
    rsp_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: defaults, wide key and channel, run, zero channel, wrapped digits
    push_lookup(0);
    push_lookup(2047);
    push_text("9:200/130,2+,/0 70000:/1");
    push_lookup(9);
    push_lookup(11);
    push_char(CH_END);
    // ignored first character still clears; huge run saturates the position
    push_char("x");
    push_lookup(9);
    push_text("65535+,,/1");
    push_char(CH_END);
    push_lookup(0);
    push_lookup(1000);
    push_lookup(2047);
    wait_drained();

    stim_count = 0;
    while (stim_count < 250) gen_string();
    // sender holds off until every result is back
    wait_drained();
    while (stim_count < 500) gen_string();
    push_char(CH_END);
    push_lookup($urandom_range(2047));
    wait_drained();
    repeat (300) @(posedge clk);

    if (errors == 0 && expected_answers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
